@@ hw/rtl/http_request_bounds_parser_top_defines.svh @@
// assertion macros shared by the request bounds parser rtl
// no dependencies; clock clk and reset rst_n are taken from the using module
`ifndef HTTP_REQUEST_BOUNDS_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_BOUNDS_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every rising clock edge outside of reset
`define HRBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked at every rising clock edge, reset included
`define HRBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRBP_ASSERT(label, prop, msg)
`define HRBP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hw/rtl/hrbp_pkg.sv @@
// shared types and constants for the request bounds parser
// no dependencies
`default_nettype none

package hrbp_pkg;

  // width of every reported offset and length
  localparam int OUT_W = 12;

  // default for the largest counted request size
  localparam int MAX_REQ_DEF = 2048;

  // delimiter bytes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef logic [OUT_W-1:0] out_val_t;

  // one input word
  typedef struct packed {
    logic [7:0] req_byte;
    logic       last_byte;
  } hrbp_item_t;

  // one result word
  typedef struct packed {
    out_val_t method_len;
    out_val_t path_start;
    out_val_t path_len;
    out_val_t query_start;
    out_val_t query_len;
    out_val_t body_start;
    out_val_t body_len;
  } hrbp_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/http_request_bounds_parser_top.sv @@
// HTTP request bounds parser: one request byte per word in, one bounds word per request out.
// Takes each byte on a valid/stall channel and reports method, path, query and body
// placement when the byte marked last arrives. Only the first MAX_REQ bytes are counted.
// Timing: one byte is accepted every cycle while the input does not stall. A byte goes into
// an input register and is scanned from there; on the last byte the result is written to the
// output register at the end of that scan cycle, and out_valid is driven from that register.
// The input stalls only when a last byte waits in the input register while the output
// register still holds an untaken, stalled result. Depends on hrbp_pkg, the defines header
// and the submodules.
`default_nettype none

`include "http_request_bounds_parser_top_defines.svh"

module http_request_bounds_parser_top #(
  parameter int MAX_REQ = hrbp_pkg::MAX_REQ_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_req_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_method_len,
  output logic [11:0]      out_path_start,
  output logic [11:0]      out_path_len,
  output logic [11:0]      out_query_start,
  output logic [11:0]      out_query_len,
  output logic [11:0]      out_body_start,
  output logic [11:0]      out_body_len
);

  hrbp_pkg::hrbp_item_t in_item;
  hrbp_pkg::hrbp_item_t a_item;
  hrbp_pkg::hrbp_res_t  res;
  hrbp_pkg::hrbp_res_t  out_res;
  logic                 a_valid;
  logic                 a_take;
  logic                 step;
  logic                 res_valid;
  logic                 can_load;

  assign in_item.req_byte  = in_req_byte;
  assign in_item.last_byte = in_last_byte;

  // a plain byte always moves on; a last byte needs room for its result
  assign a_take = !a_item.last_byte || can_load;
  assign step   = a_valid && a_take;

  hrbp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .dn_take  (a_take),
    .a_valid  (a_valid),
    .a_item   (a_item)
  );

  hrbp_scan #(
    .MAX_REQ (MAX_REQ)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (a_item),
    .res_valid (res_valid),
    .res       (res)
  );

  hrbp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields to ports
  assign out_method_len  = out_res.method_len;
  assign out_path_start  = out_res.path_start;
  assign out_path_len    = out_res.path_len;
  assign out_query_start = out_res.query_start;
  assign out_query_len   = out_res.query_len;
  assign out_body_start  = out_res.body_start;
  assign out_body_len    = out_res.body_len;

  // checks
  `HRBP_ASSERT(a_last_waits, (a_valid && a_item.last_byte && !step) |-> in_stall, "input overrun")
  `HRBP_ASSERT(a_plain_flows, (a_valid && !a_item.last_byte) |-> !in_stall, "plain byte held")

endmodule

`default_nettype wire

@@ hw/rtl/hrbp_in_reg.sv @@
// input register stage of the request bounds parser
// depends on hrbp_pkg
`default_nettype none

module hrbp_in_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire hrbp_pkg::hrbp_item_t in_item,
  input  wire logic               dn_take,
  output logic                    a_valid,
  output hrbp_pkg::hrbp_item_t    a_item
);

  logic                 a_valid_r;
  logic                 a_valid_nxt;
  hrbp_pkg::hrbp_item_t a_item_r;
  logic                 load;

  // hold only while a word sits here that the scanner cannot take
  assign in_stall = a_valid_r && !dn_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (load) begin
      a_valid_nxt = 1'b1;
    end else if (dn_take) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      a_item_r <= in_item;
    end
  end

  assign a_valid = a_valid_r;
  assign a_item  = a_item_r;

endmodule

`default_nettype wire

@@ hw/rtl/hrbp_scan.sv @@
// byte scanner: tracks token boundaries and builds the result on the last byte
// depends on hrbp_pkg and http_request_bounds_parser_top_defines.svh
`default_nettype none

`include "http_request_bounds_parser_top_defines.svh"

module hrbp_scan #(
  parameter int MAX_REQ = hrbp_pkg::MAX_REQ_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire hrbp_pkg::hrbp_item_t item,
  output logic                      res_valid,
  output hrbp_pkg::hrbp_res_t       res
);

  localparam int POS_W = $clog2(MAX_REQ + 1);
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_PATH,
    PH_QUERY,
    PH_DONE
  } phase_t;

  pos_t        pos_r,         pos_nxt;
  phase_t      phase_r,       phase_nxt;
  pos_t        method_end_r,  method_end_nxt;
  pos_t        path_begin_r,  path_begin_nxt;
  pos_t        path_end_r,    path_end_nxt;
  pos_t        query_begin_r, query_begin_nxt;
  pos_t        query_end_r,   query_end_nxt;
  logic        body_found_r,  body_found_nxt;
  pos_t        body_begin_r,  body_begin_nxt;
  logic [23:0] recent_r,      recent_nxt;

  logic [7:0] c;
  logic       counted;
  pos_t       n, mlen, ps, pe, qs, qe, bs, bl, plen, qlen;

  assign c       = item.req_byte;
  assign counted = pos_r < pos_t'(MAX_REQ);

  // state update for one byte; bytes past the size limit change nothing
  always_comb begin
    pos_nxt         = pos_r;
    phase_nxt       = phase_r;
    method_end_nxt  = method_end_r;
    path_begin_nxt  = path_begin_r;
    path_end_nxt    = path_end_r;
    query_begin_nxt = query_begin_r;
    query_end_nxt   = query_end_r;
    body_found_nxt  = body_found_r;
    body_begin_nxt  = body_begin_r;
    recent_nxt      = recent_r;
    if (counted) begin
      case (phase_r)
        PH_METHOD: begin
          if (c == hrbp_pkg::CH_SPACE) begin
            method_end_nxt = pos_r;
            path_begin_nxt = pos_t'(pos_r + 1'b1);
            phase_nxt      = PH_PATH;
          end
        end
        PH_PATH: begin
          if (c == hrbp_pkg::CH_SPACE) begin
            path_end_nxt    = pos_r;
            query_begin_nxt = pos_r;
            query_end_nxt   = pos_r;
            phase_nxt       = PH_DONE;
          end else if (c == hrbp_pkg::CH_QMARK) begin
            path_end_nxt    = pos_r;
            query_begin_nxt = pos_t'(pos_r + 1'b1);
            phase_nxt       = PH_QUERY;
          end
        end
        PH_QUERY: begin
          if (c == hrbp_pkg::CH_SPACE) begin
            query_end_nxt = pos_r;
            phase_nxt     = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      // header terminator: cr lf cr lf
      if (!body_found_r && recent_r == {hrbp_pkg::CH_CR, hrbp_pkg::CH_LF, hrbp_pkg::CH_CR}
          && c == hrbp_pkg::CH_LF) begin
        body_found_nxt = 1'b1;
        body_begin_nxt = pos_t'(pos_r + 1'b1);
      end
      recent_nxt = {recent_r[15:0], c};
      pos_nxt    = pos_t'(pos_r + 1'b1);
    end
  end

  // token bounds from the updated state
  always_comb begin
    n = pos_nxt;
    case (phase_nxt)
      PH_METHOD: begin
        mlen = n; ps = n; pe = n; qs = n; qe = n;
      end
      PH_PATH: begin
        mlen = method_end_nxt; ps = path_begin_nxt; pe = n; qs = n; qe = n;
      end
      PH_QUERY: begin
        mlen = method_end_nxt; ps = path_begin_nxt; pe = path_end_nxt;
        qs = query_begin_nxt; qe = n;
      end
      default: begin
        mlen = method_end_nxt; ps = path_begin_nxt; pe = path_end_nxt;
        qs = query_begin_nxt; qe = query_end_nxt;
      end
    endcase
    if (body_found_nxt) begin
      bs = body_begin_nxt;
      bl = pos_t'(n - body_begin_nxt);
    end else begin
      bs = n;
      bl = '0;
    end
    plen = (pe >= ps) ? pos_t'(pe - ps) : '0;
    qlen = (qe >= qs) ? pos_t'(qe - qs) : '0;
  end

  // result word, low bits of each value
  assign res_valid       = step && item.last_byte;
  assign res.method_len  = hrbp_pkg::out_val_t'(mlen);
  assign res.path_start  = hrbp_pkg::out_val_t'(ps);
  assign res.path_len    = hrbp_pkg::out_val_t'(plen);
  assign res.query_start = hrbp_pkg::out_val_t'(qs);
  assign res.query_len   = hrbp_pkg::out_val_t'(qlen);
  assign res.body_start  = hrbp_pkg::out_val_t'(bs);
  assign res.body_len    = hrbp_pkg::out_val_t'(bl);

  // scan state; the last byte returns position, phase, body flag and recent bytes to the start of a request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= PH_METHOD;
      body_found_r <= 1'b0;
      recent_r     <= '0;
    end else if (step) begin
      method_end_r  <= method_end_nxt;
      path_begin_r  <= path_begin_nxt;
      path_end_r    <= path_end_nxt;
      query_begin_r <= query_begin_nxt;
      query_end_r   <= query_end_nxt;
      body_begin_r  <= body_begin_nxt;
      if (item.last_byte) begin
        pos_r        <= '0;
        phase_r      <= PH_METHOD;
        body_found_r <= 1'b0;
        recent_r     <= '0;
      end else begin
        pos_r        <= pos_nxt;
        phase_r      <= phase_nxt;
        body_found_r <= body_found_nxt;
        recent_r     <= recent_nxt;
      end
    end
  end

  // checks
  `HRBP_ASSERT(a_last_restarts, (step && item.last_byte) |=> (pos_r == '0 && phase_r == PH_METHOD), "scan state not cleared after last byte")
  `HRBP_ASSERT(a_phase_no_back, (step && !item.last_byte && phase_r != PH_METHOD) |=> (phase_r != PH_METHOD), "phase went back to method inside a request")
  `HRBP_ASSERT(a_body_in_range, body_found_r |-> (pos_r >= body_begin_r), "body start beyond byte count")
  `HRBP_ASSERT(a_pos_limit, (pos_r == pos_t'(MAX_REQ) && step && !item.last_byte) |=> (pos_r == pos_t'(MAX_REQ)), "byte count moved past size limit")

endmodule

`default_nettype wire

@@ hw/rtl/hrbp_out_reg.sv @@
// result register stage of the request bounds parser
// depends on hrbp_pkg and http_request_bounds_parser_top_defines.svh
`default_nettype none

`include "http_request_bounds_parser_top_defines.svh"

module hrbp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire hrbp_pkg::hrbp_res_t res,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hrbp_pkg::hrbp_res_t      out_res
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  hrbp_pkg::hrbp_res_t out_res_r;

  // free when empty or when the held word leaves this cycle
  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // checks
  `HRBP_ASSERT(a_no_overwrite, load |-> can_load, "result loaded over a stalled word")
  `HRBP_ASSERT(a_load_shows, load |=> out_valid_r, "loaded result not presented")
  `HRBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

`default_nettype wire
